// ----- src/chring_pkg.sv -----
// ----------------------------------------------------------------------------
// chring_pkg: shared types and codes for the consistent hash ring
// Operation and status codes, field widths and the ring entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package chring_pkg;

    localparam int KEY_W    = 32;
    localparam int NODE_W   = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // operation codes carried on s_tuser
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // one ring slot as held in the entry memory
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] owner;
    } entry_t;

endpackage : chring_pkg

`default_nettype wire

// ----- src/consistent_hash_ring_top.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_ring_top: consistent hash ring with insert, delete, lookup
// Keeps virtual-node entries in one synchronous memory and scans it once per
// operation for key match, first free slot, smallest key and successor.
// ----------------------------------------------------------------------------
//
//  channel | ports            | content
//  --------+------------------+--------------------------------------------
//  input   | s_tvalid/tready  | tuser: opcode; tdata: key, node_id
//  result  | m_tvalid/tready  | tuser: status; tdata: owner, hit key, wrapped
//
//  Each transaction runs from acceptance through the scan, drain and commit
//  states back to idle: one read of the entry memory per slot, a drain state
//  for the last read data, a commit state that writes back and loads the
//  result, and idle, where the next one is taken. After reset a clearing pass
//  invalidates every slot before the first transaction is taken. A stalled
//  result holds the commit state until the output register is free.
//
`default_nettype none

module consistent_hash_ring_top #(
    parameter int RING_DEPTH = 64
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input channel
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [39:0]                       s_tdata,  // [31:0] key, [35:32] node_id
    input  wire  [chring_pkg::OP_W-1:0]       s_tuser,  // [1:0] opcode
    // result channel
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [39:0]                       m_tdata,  // [3:0] owner_node,
                                                        // [35:4] ring_key_hit,
                                                        // [36] wrapped
    output logic [chring_pkg::STATUS_W-1:0]   m_tuser   // [1:0] status
);
    import chring_pkg::*;

    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // entry memory
    entry_t mem [RING_DEPTH];
    entry_t rd_data_reg;
    logic   rd_pend_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // control and trackers
    state_t              state_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [NODE_W-1:0]   node_reg;

    logic                match_found_reg;
    logic [ADDR_W-1:0]   match_idx_reg;
    logic                free_found_reg;
    logic [ADDR_W-1:0]   free_idx_reg;
    logic                least_found_reg;
    logic [KEY_W-1:0]    least_key_reg;
    logic [NODE_W-1:0]   least_owner_reg;
    logic                succ_found_reg;
    logic [KEY_W-1:0]    succ_key_reg;
    logic [NODE_W-1:0]   succ_owner_reg;

    // output register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [NODE_W-1:0]   owner_reg;
    logic [KEY_W-1:0]    hit_reg;
    logic                wrap_reg;

    logic                s_fire;
    logic                out_free;
    logic                commit_go;
    logic                upd_match;
    logic                upd_free;
    logic                upd_least;
    logic                upd_succ;

    logic [STATUS_W-1:0] status_next;
    logic [NODE_W-1:0]   owner_next;
    logic [KEY_W-1:0]    hit_next;
    logic                wrap_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit_go = (state_reg == ST_COMMIT) && out_free;
    assign rd_en     = (state_reg == ST_SCAN);

    // tracker updates from the entry read in the previous cycle
    assign upd_match = rd_pend_reg && rd_data_reg.valid && !match_found_reg
                       && (rd_data_reg.key == key_reg);
    assign upd_free  = rd_pend_reg && !rd_data_reg.valid && !free_found_reg;
    assign upd_least = rd_pend_reg && rd_data_reg.valid
                       && (!least_found_reg || (rd_data_reg.key < least_key_reg));
    assign upd_succ  = rd_pend_reg && rd_data_reg.valid && (rd_data_reg.key > key_reg)
                       && (!succ_found_reg || (rd_data_reg.key < succ_key_reg));

    // write-back of the clearing pass and of the commit, and result of the commit
    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = cnt_reg;
        wr_data     = '0;
        status_next = STATUS_OK;
        owner_next  = '0;
        hit_next    = '0;
        wrap_next   = 1'b0;
        if (state_reg == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (commit_go) begin
            unique case (op_reg)
                OP_INSERT: begin
                    wr_data.valid = 1'b1;
                    wr_data.key   = key_reg;
                    wr_data.owner = node_reg;
                    if (match_found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                    end else if (free_found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_reg;
                    end else begin
                        status_next = STATUS_FULL;
                    end
                end
                OP_DELETE: begin
                    if (match_found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                    end
                end
                OP_LOOKUP: begin
                    if (!least_found_reg) begin
                        status_next = STATUS_EMPTY;
                    end else if (succ_found_reg) begin
                        owner_next = succ_owner_reg;
                        hit_next   = succ_key_reg;
                    end else begin
                        owner_next = least_owner_reg;
                        hit_next   = least_key_reg;
                        wrap_next  = 1'b1;
                    end
                end
                default: begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    // state machine, scan trackers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            least_found_reg <= 1'b0;
            succ_found_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
            rd_idx_reg  <= cnt_reg;

            if (upd_match) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= rd_idx_reg;
            end
            if (upd_free) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            if (upd_least) begin
                least_found_reg <= 1'b1;
                least_key_reg   <= rd_data_reg.key;
                least_owner_reg <= rd_data_reg.owner;
            end
            if (upd_succ) begin
                succ_found_reg <= 1'b1;
                succ_key_reg   <= rd_data_reg.key;
                succ_owner_reg <= rd_data_reg.owner;
            end

            // result taken and no new one loaded this cycle
            if (m_tvalid_reg && m_tready && !commit_go) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    if (cnt_reg == LAST_ADDR) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg          <= s_tuser;
                        key_reg         <= s_tdata[31:0];
                        node_reg        <= s_tdata[35:32];
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        least_found_reg <= 1'b0;
                        succ_found_reg  <= 1'b0;
                        cnt_reg         <= '0;
                        state_reg       <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cnt_reg == LAST_ADDR) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= status_next;
                        owner_reg    <= owner_next;
                        hit_reg      <= hit_next;
                        wrap_reg     <= wrap_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, wrap_reg, hit_reg, owner_reg};

`ifndef SYNTH
    // a taken input transaction closes the input side for the scan
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input accepted again straight after a transaction");

    // an insert refused on a full ring must never write
    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_go && (status_next == STATUS_FULL)) |-> !wr_en)
        else $error("write issued on a full-ring insert");

    // a successor is never below the smallest key
    a_succ_above_least: assert property (@(posedge aclk) disable iff (!aresetn)
        succ_found_reg |-> (least_found_reg && (least_key_reg <= succ_key_reg)))
        else $error("successor tracked below smallest key");

    // the successor lies strictly above the query
    a_succ_above_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_go && (op_reg == OP_LOOKUP) && succ_found_reg) |->
            (succ_key_reg > key_reg))
        else $error("successor not above lookup key");
`endif

endmodule : consistent_hash_ring_top

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the consistent hash ring
// Drives insert, delete and lookup transactions into the ring and predicts
// every result from a local copy of the ring contents. Results are compared
// field by field in arrival order. Both channels idle at random apart from
// one stretch with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import chring_pkg::*;

    localparam int RING_SLOTS   = 64;
    localparam int LIMIT_CYCLES = 1_000_000;
    // leave room for two more transactions after the last result
    localparam int DRAIN_CYCLES = 2 * (RING_SLOTS + 3);

    // the fourth opcode has no meaning and leaves the ring alone
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   owner;
        logic [KEY_W-1:0]    hit;
        logic                wrapped;
    } ring_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;    // [31:0] key, [35:32] node_id
    logic [OP_W-1:0]     s_tuser  = '0;    // [1:0] opcode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;          // [3:0] owner_node, [35:4] ring_key_hit,
                                           // [36] wrapped
    logic [STATUS_W-1:0] m_tuser;          // [1:0] status

    // local copy of the ring
    logic [KEY_W-1:0]  ring_key   [RING_SLOTS];
    logic [NODE_W-1:0] ring_owner [RING_SLOTS];
    bit                ring_used  [RING_SLOTS];
    int                live_count;

    ring_result_t pending_results[$];

    int  error_count;
    int  cycle_count;
    int  op_count [4];
    int  full_count;
    int  empty_count;
    int  wrap_count;
    bit  steady;           // no idling on either side while set

    consistent_hash_ring_top #(
        .RING_DEPTH (RING_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Ring predictor: applies one operation to the local copy and returns the
    // result that the block must give for it
    // ------------------------------------------------------------------------
    function automatic ring_result_t apply_ring_op(input logic [OP_W-1:0]   op,
                                                   input logic [KEY_W-1:0]  key,
                                                   input logic [NODE_W-1:0] node);
        ring_result_t res;
        int           slot;
        int           spare;
        int           succ;
        int           least;
        res   = '0;
        slot  = -1;
        spare = -1;
        succ  = -1;
        least = -1;
        op_count[op]++;
        case (op)
            OP_INSERT: begin
                for (int i = 0; i < RING_SLOTS; i++) begin
                    if (ring_used[i] && ring_key[i] == key && slot < 0)
                        slot = i;
                    if (!ring_used[i] && spare < 0)
                        spare = i;
                end
                // present key: owner overwritten, even on a full ring
                if (slot >= 0) begin
                    ring_owner[slot] = node;
                end else if (spare < 0) begin
                    res.status = STATUS_FULL;
                    full_count++;
                end else begin
                    ring_key[spare]   = key;
                    ring_owner[spare] = node;
                    ring_used[spare]  = 1'b1;
                    live_count++;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < RING_SLOTS; i++)
                    if (ring_used[i] && ring_key[i] == key && slot < 0)
                        slot = i;
                if (slot >= 0) begin
                    ring_used[slot] = 1'b0;
                    live_count--;
                end
            end
            OP_LOOKUP: begin
                // smallest key overall and smallest key strictly above the query
                for (int i = 0; i < RING_SLOTS; i++) begin
                    if (ring_used[i]) begin
                        if (least < 0 || ring_key[i] < ring_key[least])
                            least = i;
                        if (ring_key[i] > key && (succ < 0 || ring_key[i] < ring_key[succ]))
                            succ = i;
                    end
                end
                if (least < 0) begin
                    res.status = STATUS_EMPTY;
                    empty_count++;
                end else begin
                    if (succ < 0) begin
                        succ        = least;
                        res.wrapped = 1'b1;
                        wrap_count++;
                    end
                    res.owner = ring_owner[succ];
                    res.hit   = ring_key[succ];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // key of a random live entry, or a random key on an empty ring
    function automatic logic [KEY_W-1:0] live_key();
        int start;
        int idx;
        start = $urandom_range(RING_SLOTS - 1);
        for (int i = 0; i < RING_SLOTS; i++) begin
            idx = (start + i) % RING_SLOTS;
            if (ring_used[idx])
                return ring_key[idx];
        end
        return $urandom();
    endfunction

    // random owning node
    function automatic logic [NODE_W-1:0] rand_node();
        return NODE_W'($urandom_range(15));
    endfunction

    // ------------------------------------------------------------------------
    // Input side: offer one transaction, wait for acceptance, predict it.
    // Entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_ring_op(input logic [OP_W-1:0]   op,
                                input logic [KEY_W-1:0]  key,
                                input logic [NODE_W-1:0] node);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 35)
            gap = $urandom_range(1, 80);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, node, key};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_ring_op(op, key, node));
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        ring_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                check_field("status",       32'(m_tuser),       32'(want.status));
                check_field("owner_node",   32'(m_tdata[3:0]),  32'(want.owner));
                check_field("ring_key_hit", m_tdata[35:4],      want.hit);
                check_field("wrapped",      32'(m_tdata[36]),   32'(want.wrapped));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // lookups, deletes and the unused opcode on a ring with nothing in it
    task automatic test_empty_ring();
        send_ring_op(OP_LOOKUP, 32'h0000_0000, 4'h0);
        send_ring_op(OP_LOOKUP, 32'hFFFF_FFFF, 4'hF);
        send_ring_op(OP_DELETE, 32'h1234_5678, 4'hA);
        send_ring_op(OP_NONE,   32'hFFFF_FFFF, 4'hF);
        send_ring_op(OP_NONE,   32'h0000_0000, 4'h0);
    endtask

    // extreme keys, successor edges, wrap, overwrite and absent delete
    task automatic test_boundaries();
        send_ring_op(OP_INSERT, 32'h0000_0000, 4'h0);
        send_ring_op(OP_INSERT, 32'hFFFF_FFFF, 4'hF);
        send_ring_op(OP_INSERT, 32'h8000_0000, 4'h9);
        send_ring_op(OP_LOOKUP, 32'h0000_0000, 4'h3);
        send_ring_op(OP_LOOKUP, 32'h7FFF_FFFF, 4'h0);
        send_ring_op(OP_LOOKUP, 32'h8000_0000, 4'h0);
        send_ring_op(OP_LOOKUP, 32'hFFFF_FFFE, 4'h0);
        send_ring_op(OP_LOOKUP, 32'hFFFF_FFFF, 4'h0);   // wraps to key zero
        send_ring_op(OP_INSERT, 32'h8000_0000, 4'h5);   // owner overwritten
        send_ring_op(OP_LOOKUP, 32'h7FFF_FFFF, 4'hC);
        send_ring_op(OP_DELETE, 32'h0000_0000, 4'h7);
        send_ring_op(OP_LOOKUP, 32'hFFFF_FFFF, 4'h0);   // wraps past the gap
        send_ring_op(OP_DELETE, 32'h0000_0000, 4'h0);   // already gone
        send_ring_op(OP_DELETE, 32'hFFFF_FFFF, 4'hF);
        send_ring_op(OP_LOOKUP, 32'h8000_0000, 4'h0);   // single entry, wraps to itself
        send_ring_op(OP_DELETE, 32'h8000_0000, 4'h0);
        send_ring_op(OP_LOOKUP, 32'h0000_0005, 4'h0);
    endtask

    // fill every slot, then refused inserts, overwrites and lookups on a full ring, refill, empty
    task automatic test_fill_to_full();
        logic [KEY_W-1:0] key;
        while (live_count < RING_SLOTS)
            send_ring_op(OP_INSERT, $urandom(), rand_node());
        repeat (12)
            send_ring_op(OP_INSERT, $urandom(), rand_node());
        repeat (6)
            send_ring_op(OP_INSERT, live_key(), rand_node());
        repeat (10) begin
            key = ($urandom_range(1) != 0) ? live_key() : $urandom();
            send_ring_op(OP_LOOKUP, key, rand_node());
        end
        repeat (3)
            send_ring_op(OP_DELETE, live_key(), rand_node());
        repeat (4)
            send_ring_op(OP_INSERT, $urandom(), rand_node());
        while (live_count > 0)
            send_ring_op(OP_DELETE, live_key(), rand_node());
    endtask

    // mixed traffic: a growing phase, then a shrinking phase
    task automatic test_random_mix();
        int               roll;
        int               insert_pct;
        int               delete_pct;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        for (int phase = 0; phase < 2; phase++) begin
            insert_pct = (phase == 0) ? 45 : 20;
            delete_pct = (phase == 0) ? 20 : 45;
            for (int n = 0; n < 250; n++) begin
                steady = (phase == 0 && n >= 60 && n < 160);
                roll   = $urandom_range(99);
                key    = $urandom();
                if (roll < insert_pct) begin
                    op = OP_INSERT;
                    if ($urandom_range(99) < 30)
                        key = live_key();
                end else if (roll < insert_pct + delete_pct) begin
                    op = OP_DELETE;
                    if ($urandom_range(99) < 75)
                        key = live_key();
                end else if (roll < 95) begin
                    op = OP_LOOKUP;
                    // queries on and either side of a live key
                    if ($urandom_range(1) != 0) begin
                        key = live_key();
                        case ($urandom_range(2))
                            0:       key = key - 1;
                            1:       key = key + 1;
                            default: ;
                        endcase
                    end
                end else begin
                    op = OP_NONE;
                end
                send_ring_op(op, key, rand_node());
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_ring();
        test_boundaries();
        test_fill_to_full();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d inserts, %0d deletes, %0d lookups, %0d unused-opcode transactions",
                 op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_LOOKUP],
                 op_count[OP_NONE]);
        $display("%0d inserts refused on a full ring, %0d lookups on an empty ring, %0d wrapped",
                 full_count, empty_count, wrap_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("run stopped by the watchdog after %0d cycles", cycle_count);
        $display("tb_top: errors");
        $finish;
    end

endmodule : tb_top
